// ===== design/assert_macros.svh =====
// Assertion helpers shared by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define PLTI_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Implication checked at every clock edge, reset included.
`define PLTI_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== design/plti_pkg.sv =====
package plti_pkg;
   localparam int unsigned LANES = 4;
   localparam int unsigned WORD_W = 32;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_INTERP = 2'd2,
      OP_NOP    = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_OUTSIDE  = 2'd1,
      ST_TOO_FEW  = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_APPEND,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_COMP_RD,
      S_COMP_LEFT,
      S_COMP_RIGHT,
      S_MUL,
      S_DIV,
      S_DIV_DONE,
      S_DONE
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > 34'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -34'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction
endpackage

// ===== design/piecewise_linear_table_interpolator_top.sv =====
// Piecewise linear table interpolator in Q16.16. Raise start while busy is low
// to issue a word: clear, append or interpolate. Every word yields exactly one
// result, shown for one cycle with rsp_valid high; the receiver cannot stall,
// so it must capture the result on that cycle. An interpolate scans the time
// memory to find the first bracketing interval, then runs each component in
// use through a shared divider, which a zero-length interval skips. Busy falls
// in the cycle the result is shown, so the next word can be taken then. The
// sample memories need no clearing pass: only entries below the point count
// are ever read.
module piecewise_linear_table_interpolator_top #(
   parameter int unsigned MAX_POINTS = 256,
   parameter int unsigned DIMENSIONS = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic signed [31:0] req_time_value,
   input  logic signed [31:0] req_comp_in_0,
   input  logic signed [31:0] req_comp_in_1,
   input  logic signed [31:0] req_comp_in_2,
   input  logic signed [31:0] req_comp_in_3,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_wr_data,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_comp_out_0,
   output logic signed [31:0] rsp_comp_out_1,
   output logic signed [31:0] rsp_comp_out_2,
   output logic signed [31:0] rsp_comp_out_3
);
   localparam int unsigned PW = $clog2(MAX_POINTS);
   localparam int unsigned CW = $clog2(MAX_POINTS + 1);
   localparam int unsigned DW = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
   localparam int unsigned LIM = (DIMENSIONS < plti_pkg::LANES) ? DIMENSIONS
                                                                : plti_pkg::LANES;
   localparam int unsigned CDEPTH = MAX_POINTS * DIMENSIONS;
   localparam int unsigned CAW = $clog2(CDEPTH);

   plti_pkg::state_type state_ff, state_in;

   logic [2:0]  dims_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [1:0]  op_ff;
   logic signed [31:0] t_ff;
   logic signed [31:0] cin_ff [plti_pkg::LANES];
   logic [PW-1:0] k_ff, k_in;
   logic [2:0]  lane_ff, lane_in;
   logic [2:0]  ndims;
   logic signed [31:0] tprev_ff, tprev_in;
   logic signed [31:0] t0_ff, t0_in;
   logic signed [32:0] dt_ff, dt_in;
   logic signed [31:0] x0_ff, x0_in;
   logic        neg_ff, neg_in;
   logic [31:0] mag_ff, mag_in;
   logic signed [31:0] res_ff [plti_pkg::LANES];
   logic signed [31:0] res_in [plti_pkg::LANES];
   logic        have_prev_ff, have_prev_in;
   logic        rsp_valid_in;
   logic [1:0]  status_ff, status_in;

   // Memory ports.
   logic          t_we;
   logic [PW-1:0] t_waddr, t_raddr;
   logic [31:0]   t_rdata;
   logic          c_we;
   logic [CAW-1:0] c_waddr, c_raddr;
   logic [31:0]   c_wdata, c_rdata;

   logic        div_start;
   logic        div_busy;
   logic        div_done;
   logic [63:0] quotient;
   logic [32:0] a_val;
   logic [63:0] product;
   logic signed [33:0] sum;

   // Dimension register; zero acts as one, large values saturate.
   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff <= 3'd1;
      end else if (csr_wr_en) begin
         dims_ff <= csr_wr_data;
      end
   end

   always_comb begin
      if (dims_ff == 3'd0) begin
         ndims = 3'd1;
      end else if (dims_ff > 3'(LIM)) begin
         ndims = 3'(LIM);
      end else begin
         ndims = dims_ff;
      end
   end

   plti_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_times (
      .clock(clock), .wr_en(t_we), .wr_addr(t_waddr), .wr_data(t_ff),
      .rd_addr(t_raddr), .rd_data(t_rdata)
   );

   plti_ram #(.WIDTH(32), .DEPTH(CDEPTH)) u_comps (
      .clock(clock), .wr_en(c_we), .wr_addr(c_waddr), .wr_data(c_wdata),
      .rd_addr(c_raddr), .rd_data(c_rdata)
   );

   // Registered product feeding the divider: |t - t0| times |dx|. The magnitude
   // settles in S_MUL, so the product is ready when S_DIV starts the divider.
   assign a_val = 33'(t_ff - t0_ff);
   always_ff @(posedge clock) begin
      product <= 64'(a_val[31:0]) * 64'(mag_ff) + (a_val[32] ? (64'(mag_ff) << 32) : 64'd0);
   end

   plti_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(product), .divisor(dt_ff), .quotient(quotient),
      .busy(div_busy), .done(div_done)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         plti_pkg::S_IDLE: begin
            if (start) begin
               unique case (plti_pkg::opcode_type'(req_opcode))
                  plti_pkg::OP_APPEND: state_in = plti_pkg::S_APPEND;
                  plti_pkg::OP_INTERP: state_in = plti_pkg::S_SCAN_RD;
                  default:             state_in = plti_pkg::S_DONE;
               endcase
            end
         end
         plti_pkg::S_APPEND: begin
            if (lane_ff == 3'(DIMENSIONS - 1) || count_ff >= CW'(MAX_POINTS)) begin
               state_in = plti_pkg::S_DONE;
            end
         end
         plti_pkg::S_SCAN_RD: begin
            if (count_ff < CW'(2)) begin
               state_in = plti_pkg::S_DONE;
            end else begin
               state_in = plti_pkg::S_SCAN_CMP;
            end
         end
         plti_pkg::S_SCAN_CMP: begin
            if (have_prev_ff && t_ff >= tprev_ff && t_ff <= $signed(t_rdata)) begin
               state_in = plti_pkg::S_COMP_RD;
            end else if (CW'(k_ff) + CW'(1) >= count_ff) begin
               state_in = plti_pkg::S_DONE;
            end else begin
               state_in = plti_pkg::S_SCAN_RD;
            end
         end
         plti_pkg::S_COMP_RD:    state_in = plti_pkg::S_COMP_LEFT;
         plti_pkg::S_COMP_LEFT:  state_in = plti_pkg::S_COMP_RIGHT;
         plti_pkg::S_COMP_RIGHT: state_in = plti_pkg::S_MUL;
         plti_pkg::S_MUL:        state_in = plti_pkg::S_DIV;
         plti_pkg::S_DIV:        state_in = plti_pkg::S_DIV_DONE;
         plti_pkg::S_DIV_DONE: begin
            if (div_done || dt_ff == 33'sd0) begin
               if (lane_ff + 3'd1 >= ndims) begin
                  state_in = plti_pkg::S_DONE;
               end else begin
                  state_in = plti_pkg::S_COMP_RD;
               end
            end
         end
         plti_pkg::S_DONE: state_in = plti_pkg::S_IDLE;
         default:          state_in = plti_pkg::S_IDLE;
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      count_in     = count_ff;
      k_in         = k_ff;
      lane_in      = lane_ff;
      tprev_in     = tprev_ff;
      t0_in        = t0_ff;
      dt_in        = dt_ff;
      x0_in        = x0_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      have_prev_in = have_prev_ff;
      status_in    = status_ff;
      rsp_valid_in = 1'b0;
      for (int i = 0; i < plti_pkg::LANES; i++) begin
         res_in[i] = res_ff[i];
      end
      t_we    = 1'b0;
      t_waddr = count_ff[PW-1:0];
      t_raddr = k_ff;
      c_we    = 1'b0;
      c_waddr = CAW'(count_ff[PW-1:0]) * CAW'(DIMENSIONS) + CAW'(lane_ff);
      c_wdata = (lane_ff < 3'(plti_pkg::LANES)) ? cin_ff[lane_ff[1:0]] : 32'd0;
      c_raddr = CAW'(k_ff) * CAW'(DIMENSIONS) + CAW'(lane_ff);
      div_start = 1'b0;
      sum = '0;

      unique case (state_ff)
         plti_pkg::S_IDLE: begin
            lane_in      = '0;
            k_in         = '0;
            have_prev_in = 1'b0;
            status_in    = plti_pkg::ST_OK;
            for (int i = 0; i < plti_pkg::LANES; i++) begin
               res_in[i] = '0;
            end
            if (start && plti_pkg::opcode_type'(req_opcode) == plti_pkg::OP_CLEAR) begin
               count_in = '0;
            end
         end
         plti_pkg::S_APPEND: begin
            if (count_ff >= CW'(MAX_POINTS)) begin
               status_in = plti_pkg::ST_FULL;
            end else begin
               c_we    = 1'b1;
               lane_in = lane_ff + 3'd1;
               if (lane_ff == 3'd0) begin
                  t_we = 1'b1;
               end
               if (lane_ff == 3'(DIMENSIONS - 1)) begin
                  count_in = count_ff + CW'(1);
               end
            end
         end
         plti_pkg::S_SCAN_RD: begin
            if (count_ff < CW'(2)) begin
               status_in = plti_pkg::ST_TOO_FEW;
            end
         end
         plti_pkg::S_SCAN_CMP: begin
            if (have_prev_ff && t_ff >= tprev_ff && t_ff <= $signed(t_rdata)) begin
               // Interval [k-1, k] brackets the query.
               k_in   = k_ff - PW'(1);
               t0_in  = tprev_ff;
               dt_in  = 33'($signed(t_rdata)) - 33'(tprev_ff);
            end else begin
               if (CW'(k_ff) + CW'(1) >= count_ff) begin
                  status_in = plti_pkg::ST_OUTSIDE;
               end else begin
                  k_in = k_ff + PW'(1);
               end
               have_prev_in = 1'b1;
               tprev_in     = t_rdata;
            end
         end
         plti_pkg::S_COMP_RD: begin
            c_raddr = CAW'(k_ff) * CAW'(DIMENSIONS) + CAW'(lane_ff);
         end
         plti_pkg::S_COMP_LEFT: begin
            x0_in   = c_rdata;
            c_raddr = CAW'(CAW'(k_ff) + CAW'(1)) * CAW'(DIMENSIONS) + CAW'(lane_ff);
         end
         plti_pkg::S_COMP_RIGHT: begin
            if ($signed(c_rdata) < x0_ff) begin
               neg_in = 1'b1;
               mag_in = 32'(33'(x0_ff) - 33'($signed(c_rdata)));
            end else begin
               neg_in = 1'b0;
               mag_in = 32'(33'($signed(c_rdata)) - 33'(x0_ff));
            end
         end
         plti_pkg::S_DIV: begin
            div_start = (dt_ff != 33'sd0);
         end
         plti_pkg::S_DIV_DONE: begin
            if (dt_ff == 33'sd0) begin
               res_in[lane_ff[1:0]] = x0_ff;
               lane_in = lane_ff + 3'd1;
            end else if (div_done) begin
               if (quotient > 64'h3_ffff_ffff) begin
                  sum = neg_ff ? -34'sh2_0000_0000 : 34'sh1_ffff_ffff;
               end else if (neg_ff) begin
                  sum = 34'(x0_ff) - $signed({1'b0, quotient[32:0]});
               end else begin
                  sum = 34'(x0_ff) + $signed({1'b0, quotient[32:0]});
               end
               res_in[lane_ff[1:0]] = plti_pkg::sat32(sum);
               lane_in = lane_ff + 3'd1;
            end
         end
         plti_pkg::S_DONE: begin
            rsp_valid_in = 1'b1;
            if (status_ff != plti_pkg::ST_OK || op_ff != plti_pkg::OP_INTERP) begin
               for (int i = 0; i < plti_pkg::LANES; i++) begin
                  res_in[i] = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= plti_pkg::S_IDLE;
         count_ff  <= '0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         rsp_valid <= rsp_valid_in;
      end
      if (state_ff == plti_pkg::S_IDLE && start) begin
         op_ff <= req_opcode;
         t_ff  <= req_time_value;
         cin_ff[0] <= req_comp_in_0;
         cin_ff[1] <= req_comp_in_1;
         cin_ff[2] <= req_comp_in_2;
         cin_ff[3] <= req_comp_in_3;
      end
      k_ff         <= k_in;
      lane_ff      <= lane_in;
      tprev_ff     <= tprev_in;
      t0_ff        <= t0_in;
      dt_ff        <= dt_in;
      x0_ff        <= x0_in;
      neg_ff       <= neg_in;
      mag_ff       <= mag_in;
      have_prev_ff <= have_prev_in;
      status_ff    <= status_in;
      for (int i = 0; i < plti_pkg::LANES; i++) begin
         res_ff[i] <= res_in[i];
      end
   end

   // The result word registers are settled by the end of DONE and are only
   // cleared at the end of the following idle cycle, so they are stable in the
   // one cycle that rsp_valid is high.
   assign busy           = (state_ff != plti_pkg::S_IDLE);
   assign rsp_status     = status_ff;
   assign rsp_comp_out_0 = res_ff[0];
   assign rsp_comp_out_1 = res_ff[1];
   assign rsp_comp_out_2 = res_ff[2];
   assign rsp_comp_out_3 = res_ff[3];

   logic unused_ok;
   assign unused_ok = div_busy & ^DW'(0);
endmodule

// ===== design/plti_ram.sv =====
module plti_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== design/plti_divider.sv =====
// Unsigned restoring divider, one quotient bit per cycle. The dividend is a
// 64-bit product; the divisor is a 33-bit positive interval length.
module plti_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [32:0] divisor,
   output logic [63:0] quotient,
   output logic        busy,
   output logic        done
);
   logic [63:0] quo_ff, quo_in;
   logic [33:0] rem_ff, rem_in;
   logic [32:0] den_ff, den_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [33:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[32:0], quo_ff[63]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quotient = quo_ff;
   assign busy     = busy_ff;
   assign done     = done_ff;
endmodule

// ===== design/plti_checker.sv =====
`include "assert_macros.svh"
module plti_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_comp_out_0,
   input logic [31:0] rsp_comp_out_1
);
   `PLTI_ASSERT(a_accept_busy, clock, reset, (start && !busy) |=> busy,
      "accepted word did not set busy")
   `PLTI_ASSERT(a_valid_pulse, clock, reset, rsp_valid |=> !rsp_valid,
      "result held longer than one cycle")
   `PLTI_ASSERT(a_zero_on_err, clock, reset,
      (rsp_valid && rsp_status != plti_pkg::ST_OK) |->
      (rsp_comp_out_0 == 32'd0 && rsp_comp_out_1 == 32'd0),
      "nonzero components on error")
   `PLTI_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (!busy && !rsp_valid),
      "not idle after reset")
endmodule

bind piecewise_linear_table_interpolator_top plti_checker u_plti_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_status(rsp_status),
   .rsp_comp_out_0(rsp_comp_out_0), .rsp_comp_out_1(rsp_comp_out_1)
);

// ===== tb/piecewise_linear_table_interpolator_top_tb.sv =====
module piecewise_linear_table_interpolator_top_tb;
   // One result word as the checker sees it: status plus four Q16.16 lanes.
   typedef struct {
      logic [1:0]         status;
      logic signed [31:0] comp [4];
   } interp_result_type;

   localparam int unsigned TABLE_DEPTH = 256;
   localparam int unsigned CYCLE_LIMIT = 3000000;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_opcode;
   logic signed [31:0] req_time_value;
   logic signed [31:0] req_comp_in_0;
   logic signed [31:0] req_comp_in_1;
   logic signed [31:0] req_comp_in_2;
   logic signed [31:0] req_comp_in_3;
   logic               csr_wr_en;
   logic [2:0]         csr_wr_data;
   logic               rsp_valid;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_comp_out_0;
   logic signed [31:0] rsp_comp_out_1;
   logic signed [31:0] rsp_comp_out_2;
   logic signed [31:0] rsp_comp_out_3;

   // Shadow copy of the block's table and dimension register.
   logic signed [31:0] shadow_times [TABLE_DEPTH];
   logic signed [31:0] shadow_comps [TABLE_DEPTH][4];
   int unsigned        shadow_count;
   logic [2:0]         shadow_dims;

   interp_result_type  pending_results [$];
   int unsigned        mismatch_count;
   int unsigned        words_sent;
   int unsigned        cycle_count;

   piecewise_linear_table_interpolator_top u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_time_value (req_time_value),
      .req_comp_in_0  (req_comp_in_0),
      .req_comp_in_1  (req_comp_in_1),
      .req_comp_in_2  (req_comp_in_2),
      .req_comp_in_3  (req_comp_in_3),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_comp_out_0 (rsp_comp_out_0),
      .rsp_comp_out_1 (rsp_comp_out_1),
      .rsp_comp_out_2 (rsp_comp_out_2),
      .rsp_comp_out_3 (rsp_comp_out_3)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Clamp a wide signed value into the Q16.16 word range.
   function automatic logic signed [31:0] clamp_q16(input longint v);
      if (v > 64'sd2147483647) begin
         return 32'sh7fffffff;
      end
      if (v < -64'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   // Computes the result of one accepted word and updates the shadow table.
   function automatic interp_result_type apply_word(input plti_pkg::opcode_type op,
                                                    input logic signed [31:0] t,
                                                    input logic signed [31:0] cin [4]);
      interp_result_type res;
      int unsigned    lanes;
      int             k;
      bit             found;
      longint         t0;
      longint         dt;
      longint         x0;
      longint         dx;
      logic [127:0]   prod;
      logic [127:0]   quot;
      res.status = plti_pkg::ST_OK;
      for (int j = 0; j < 4; j++) begin
         res.comp[j] = '0;
      end
      // A register value of zero behaves as one lane, anything above four as four.
      lanes = (shadow_dims == 0) ? 1 : (shadow_dims > 4) ? 4 : shadow_dims;
      case (op)
         plti_pkg::OP_CLEAR: begin
            shadow_count = 0;
         end
         plti_pkg::OP_APPEND: begin
            if (shadow_count >= TABLE_DEPTH) begin
               res.status = plti_pkg::ST_FULL;
            end else begin
               shadow_times[shadow_count] = t;
               for (int j = 0; j < 4; j++) begin
                  shadow_comps[shadow_count][j] = cin[j];
               end
               shadow_count++;
            end
         end
         plti_pkg::OP_INTERP: begin
            if (shadow_count < 2) begin
               res.status = plti_pkg::ST_TOO_FEW;
            end else begin
               found = 1'b0;
               k = 0;
               for (int i = 0; i + 1 < shadow_count; i++) begin
                  if (!found && t >= shadow_times[i] && t <= shadow_times[i + 1]) begin
                     found = 1'b1;
                     k = i;
                  end
               end
               if (!found) begin
                  res.status = plti_pkg::ST_OUTSIDE;
               end else begin
                  t0 = shadow_times[k];
                  dt = longint'(shadow_times[k + 1]) - t0;
                  for (int j = 0; j < lanes; j++) begin
                     x0 = shadow_comps[k][j];
                     dx = longint'(shadow_comps[k + 1][j]) - x0;
                     // A zero-length interval keeps the left sample.
                     if (dt > 0) begin
                        prod = 128'(longint'(t) - t0) * 128'(dx < 0 ? -dx : dx);
                        quot = prod / 128'(dt);
                        x0 = (dx < 0) ? x0 - longint'(quot[63:0])
                                      : x0 + longint'(quot[63:0]);
                     end
                     res.comp[j] = clamp_q16(x0);
                  end
               end
            end
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   // Presents one word and holds it until the block takes it. Start is left high
   // so that a back-to-back word follows without a gap.
   task automatic send_word(input plti_pkg::opcode_type op, input logic signed [31:0] t,
                            input logic signed [31:0] cin [4]);
      start          <= 1'b1;
      req_opcode     <= op;
      req_time_value <= t;
      req_comp_in_0  <= cin[0];
      req_comp_in_1  <= cin[1];
      req_comp_in_2  <= cin[2];
      req_comp_in_3  <= cin[3];
      do begin
         @(posedge clock);
      end while (busy);
      pending_results.push_back(apply_word(op, t, cin));
      words_sent++;
   endtask

   // Random idle time after a word: mostly none or short, now and then long.
   task automatic idle_gap();
      int unsigned n;
      case ($urandom_range(0, 9))
         0, 1, 2: n = 0;
         9:       n = $urandom_range(20, 60);
         default: n = $urandom_range(1, 4);
      endcase
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Lowers start and waits for every outstanding result.
   task automatic drain_results();
      start <= 1'b0;
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_dims(input logic [2:0] value);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      shadow_dims = value;
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [31:0] random_word();
      case ($urandom_range(0, 7))
         0:       return 32'sh80000000;
         1:       return 32'sh7fffffff;
         2:       return '0;
         3:       return $urandom_range(0, 2000) - 1000;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_point(input logic signed [31:0] t, input logic signed [31:0] a,
                             input logic signed [31:0] b, input logic signed [31:0] c,
                             input logic signed [31:0] d);
      logic signed [31:0] cin [4];
      cin = '{a, b, c, d};
      send_word(plti_pkg::OP_APPEND, t, cin);
      idle_gap();
   endtask

   task automatic send_simple(input plti_pkg::opcode_type op, input logic signed [31:0] t);
      logic signed [31:0] cin [4];
      cin = '{random_word(), random_word(), random_word(), random_word()};
      send_word(op, t, cin);
      idle_gap();
   endtask

   // Empty and single-point tables must refuse a query; no-op is harmless.
   task automatic test_small_tables();
      send_simple(plti_pkg::OP_INTERP, 0);
      send_simple(plti_pkg::OP_NOP, 32'sh7fffffff);
      send_point(32'sh00010000, 1, 2, 3, 4);
      send_simple(plti_pkg::OP_INTERP, 32'sh00010000);
      send_simple(plti_pkg::OP_CLEAR, 0);
      send_simple(plti_pkg::OP_INTERP, 0);
   endtask

   // Full-range times and components, bracket ends and out-of-range
   // queries, with all four lanes enabled.
   task automatic test_extremes();
      write_dims(3'd4);
      send_simple(plti_pkg::OP_CLEAR, 0);
      send_point(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 0, 32'sh00010000);
      send_point(0, 32'sh7fffffff, 32'sh80000000, -1, 32'sh7fffffff);
      send_point(0, 5, 6, 7, 8);
      send_point(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 0);
      send_simple(plti_pkg::OP_INTERP, 32'sh80000000);
      send_simple(plti_pkg::OP_INTERP, 32'sh7fffffff);
      send_simple(plti_pkg::OP_INTERP, 0);
      send_simple(plti_pkg::OP_INTERP, 32'shc0000001);
      send_simple(plti_pkg::OP_INTERP, 32'sh3fffffff);
      // Decreasing times leave a query outside the first interval unmatched.
      send_simple(plti_pkg::OP_CLEAR, 0);
      send_point(100, 1, 1, 1, 1);
      send_point(200, 2, 2, 2, 2);
      send_point(50, 3, 3, 3, 3);
      send_simple(plti_pkg::OP_INTERP, 75);
      send_simple(plti_pkg::OP_INTERP, 201);
      send_simple(plti_pkg::OP_INTERP, 99);
   endtask

   // Register values outside one to four are folded into range.
   task automatic test_dims_register();
      logic [2:0] settings [6];
      settings = '{3'd0, 3'd7, 3'd2, 3'd5, 3'd3, 3'd1};
      foreach (settings[i]) begin
         write_dims(settings[i]);
         send_simple(plti_pkg::OP_INTERP, 150);
      end
   endtask

   // Fill the table, overflow it by one, then query the far end and the middle.
   task automatic test_full_table();
      int times_sorted [$];
      write_dims(3'd4);
      send_simple(plti_pkg::OP_CLEAR, 0);
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         times_sorted.push_back(int'($urandom));
      end
      times_sorted.sort();
      foreach (times_sorted[i]) begin
         send_point(times_sorted[i], random_word(), random_word(), random_word(),
                    random_word());
      end
      send_simple(plti_pkg::OP_APPEND, 32'sh7fffffff);
      send_simple(plti_pkg::OP_INTERP, times_sorted[TABLE_DEPTH - 1]);
      send_simple(plti_pkg::OP_INTERP, times_sorted[TABLE_DEPTH / 2]);
   endtask

   // Random tables of mostly small size, mostly sorted, each followed by
   // queries that usually fall inside an interval.
   task automatic test_random_tables(input int unsigned word_budget);
      int          times_sorted [$];
      int unsigned n;
      int unsigned k;
      longint      span;
      longint      t;
      int unsigned stop_at;
      stop_at = words_sent + word_budget;
      while (words_sent < stop_at) begin
         if ($urandom_range(0, 5) == 0) begin
            write_dims(3'($urandom_range(0, 7)));
         end
         send_simple(plti_pkg::OP_CLEAR, random_word());
         case ($urandom_range(0, 19))
            0:       n = $urandom_range(0, 1);
            1:       n = $urandom_range(30, 60);
            default: n = $urandom_range(2, 10);
         endcase
         times_sorted.delete();
         for (int i = 0; i < n; i++) begin
            times_sorted.push_back(($urandom_range(0, 3) == 0) ? int'(random_word())
                                                              : int'($urandom));
         end
         // A few tables keep duplicate times to make zero-length intervals.
         if (n > 2 && $urandom_range(0, 3) == 0) begin
            times_sorted[1] = times_sorted[0];
         end
         if ($urandom_range(0, 7) != 0) begin
            times_sorted.sort();
         end
         foreach (times_sorted[i]) begin
            send_point(times_sorted[i], random_word(), random_word(), random_word(),
                       random_word());
         end
         repeat ($urandom_range(3, 8)) begin
            if (n >= 2 && $urandom_range(0, 9) > 1) begin
               k = $urandom_range(0, n - 2);
               span = longint'(times_sorted[k + 1]) - times_sorted[k];
               t = times_sorted[k];
               if (span > 0) begin
                  t = t + ({$urandom, $urandom} & 64'h7fffffffffffffff) % (span + 1);
               end
               send_simple(plti_pkg::OP_INTERP, t[31:0]);
            end else begin
               case ($urandom_range(0, 3))
                  0:       send_simple(plti_pkg::OP_NOP, random_word());
                  1:       send_simple(plti_pkg::OP_APPEND, random_word());
                  default: send_simple(plti_pkg::OP_INTERP, random_word());
               endcase
            end
         end
      end
   endtask

   // Each result is checked against the oldest expectation on the cycle it shows.
   always @(posedge clock) begin
      interp_result_type  exp_word;
      logic signed [31:0] got [4];
      if (!reset && rsp_valid) begin
         got = '{rsp_comp_out_0, rsp_comp_out_1, rsp_comp_out_2, rsp_comp_out_3};
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("result with none expected: status %0d", rsp_status);
            end
         end else begin
            exp_word = pending_results.pop_front();
            if (rsp_status !== exp_word.status || got[0] !== exp_word.comp[0] ||
                got[1] !== exp_word.comp[1] || got[2] !== exp_word.comp[2] ||
                got[3] !== exp_word.comp[3]) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch: expected status %0d comps %h %h %h %h", exp_word.status,
                           exp_word.comp[0], exp_word.comp[1], exp_word.comp[2],
                           exp_word.comp[3]);
                  $display("          actual   status %0d comps %h %h %h %h", rsp_status,
                           got[0], got[1], got[2], got[3]);
               end
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[piecewise_linear_table_interpolator_top] ERROR");
         $finish;
      end
   end

   initial begin
      start          = 1'b0;
      reset          = 1'b1;
      req_opcode     = plti_pkg::OP_NOP;
      req_time_value = '0;
      req_comp_in_0  = '0;
      req_comp_in_1  = '0;
      req_comp_in_2  = '0;
      req_comp_in_3  = '0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      shadow_count   = 0;
      shadow_dims    = 3'd1;
      mismatch_count = 0;
      words_sent     = 0;
      cycle_count    = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_small_tables();
      test_extremes();
      test_dims_register();
      test_full_table();
      test_random_tables(160);

      drain_results();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("[piecewise_linear_table_interpolator_top] OK");
      end else begin
         $display("[piecewise_linear_table_interpolator_top] ERROR");
      end
      $finish;
   end
endmodule
